### rtl/core/i2c_bit_level_master_unit_defines.svh
// Assertion macros for the I2C bit-level master unit.
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm assertion failed");
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  localparam logic [2:0] CMD_START     = 3'd0;
  localparam logic [2:0] CMD_STOP      = 3'd1;
  localparam logic [2:0] CMD_WRITE     = 3'd2;
  localparam logic [2:0] CMD_READ_ACK  = 3'd3;
  localparam logic [2:0] CMD_READ_NACK = 3'd4;
  localparam logic [2:0] CMD_POLL      = 3'd5;
  localparam logic [2:0] CMD_POLL_BODY = 3'd6;

  localparam logic [7:0] TOP_BIT = 8'h80;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       poll_nack;
  } rsp_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] cmd;
    logic [7:0] shift_byte;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       ack_seen;
  } state_t;

  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd24) r = r - 5'd24;
    if (r >= 5'd12) r = r - 5'd12;
    if (r >= 5'd6) r = r - 5'd6;
    if (r >= 5'd3) r = r - 5'd3;
    return r[1:0];
  endfunction

endpackage

### rtl/core/i2cm_step.sv
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::req_t   req,
  output i2cm_pkg::state_t st_next,
  output i2cm_pkg::rsp_t   rsp_next
);
  import i2cm_pkg::*;

  state_t     n;
  logic       run;
  logic       last;
  logic [4:0] idx;
  logic       do_bit;
  logic       do_start;
  logic       do_stop;
  logic [4:0] sidx;

  always_comb begin
    n        = st;
    run      = 1'b0;
    last     = 1'b0;
    idx      = '0;
    do_bit   = 1'b0;
    do_start = 1'b0;
    do_stop  = 1'b0;
    sidx     = '0;
    rsp_next = '0;

    if (st.phase != 5'd0) begin
      idx = st.phase - 5'd1;
      run = 1'b1;
    end else if (req.cmd_valid && req.mode <= CMD_POLL) begin
      n.cmd        = req.mode;
      n.shift_byte = (req.mode == CMD_WRITE || req.mode == CMD_POLL) ? req.tx_byte : 8'd0;
      if (req.mode == CMD_POLL) n.ack_seen = 1'b0;
      run = 1'b1;
    end

    if (run) begin
      unique case (n.cmd)
        CMD_START, CMD_POLL: begin
          do_start = 1'b1;
          sidx     = idx;
        end
        CMD_STOP: begin
          do_stop = 1'b1;
          sidx    = idx;
        end
        CMD_WRITE: begin
          if (idx < 5'd24) begin
            do_bit = 1'b1;
          end else begin
            unique case (idx)
              5'd24: begin
                n.sda_level  = 1'b0;
                n.sda_enable = 1'b1;
              end
              5'd25: n.scl_level = 1'b1;
              5'd26: begin
                n.scl_level = 1'b0;
                last        = 1'b1;
              end
              default: last = 1'b1;
            endcase
          end
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          if (idx == 5'd0) begin
            n.sda_enable = 1'b0;
            n.sda_level  = 1'b1;
          end else if (idx <= 5'd16) begin
            if (idx[0]) begin
              n.scl_level  = 1'b1;
              n.shift_byte = {n.shift_byte[6:0], req.sda_in};
            end else begin
              n.scl_level = 1'b0;
            end
          end else begin
            unique case (idx)
              5'd17: begin
                n.sda_level  = (n.cmd == CMD_READ_NACK);
                n.sda_enable = 1'b1;
              end
              5'd18: n.scl_level = 1'b1;
              5'd19: begin
                n.scl_level = 1'b0;
                last        = 1'b1;
              end
              default: last = 1'b1;
            endcase
          end
        end
        CMD_POLL_BODY: begin
          if (idx < 5'd24) begin
            do_bit = 1'b1;
          end else if (idx == 5'd24) begin
            n.sda_enable = 1'b0;
            n.sda_level  = 1'b1;
          end else if (idx == 5'd25) begin
            n.scl_level = 1'b1;
            n.ack_seen  = req.sda_in;
          end else begin
            do_stop = 1'b1;
            sidx    = idx - 5'd26;
          end
        end
        default: last = 1'b1;
      endcase

      if (do_bit) begin
        unique case (mod3(idx))
          2'd0: begin
            n.sda_level  = |(n.shift_byte & TOP_BIT);
            n.sda_enable = 1'b1;
          end
          2'd1: n.scl_level = 1'b1;
          default: begin
            n.scl_level  = 1'b0;
            n.shift_byte = {n.shift_byte[6:0], 1'b0};
          end
        endcase
      end

      if (do_start) begin
        unique case (sidx)
          5'd0: begin
            n.scl_level  = 1'b1;
            n.sda_enable = 1'b1;
          end
          5'd1: n.sda_level = 1'b1;
          5'd2: n.sda_level = 1'b0;
          5'd3: begin
            n.scl_level = 1'b0;
            last        = 1'b1;
          end
          default: last = 1'b1;
        endcase
      end

      if (do_stop) begin
        unique case (sidx)
          5'd0: begin
            n.scl_level  = 1'b0;
            n.sda_enable = 1'b1;
          end
          5'd1: n.sda_level = 1'b0;
          5'd2: n.scl_level = 1'b1;
          5'd3: begin
            n.sda_level = 1'b1;
            last        = 1'b1;
          end
          default: last = 1'b1;
        endcase
      end

      rsp_next.busy_res = 1'b1;
      if (last && n.cmd == CMD_POLL && idx == 5'd3) begin
        n.cmd   = CMD_POLL_BODY;
        n.phase = 5'd1;
      end else if (last) begin
        rsp_next.done_res = 1'b1;
        if (n.cmd == CMD_READ_ACK || n.cmd == CMD_READ_NACK) rsp_next.rx_byte = n.shift_byte;
        if (n.cmd == CMD_POLL_BODY) rsp_next.poll_nack = n.ack_seen;
        n.phase = 5'd0;
      end else begin
        n.phase = idx + 5'd2;
      end
    end

    rsp_next.scl_out   = n.scl_level;
    rsp_next.sda_out   = n.sda_level;
    rsp_next.sda_drive = n.sda_enable;
    st_next            = n;
  end

endmodule

### rtl/core/i2c_bit_level_master_unit.sv
// I2C bit-level master. Each request is one bus tick (optional command, byte,
// sampled SDA); each produces exactly one response with the pin levels for that
// tick plus busy/done and, on a done tick, the read byte or the poll NACK bit.
// One request is taken per clock. Its response passes from the input register
// through the combinational step logic into the response register, where it
// waits to be accepted. A stalled response holds the input register, which
// then stalls requests.
// Commands offered while a sequence is running are ignored.
`include "i2c_bit_level_master_unit_defines.svh"

module i2c_bit_level_master_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  i2cm_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output i2cm_pkg::rsp_t  rsp_data
);
  import i2cm_pkg::*;

  logic   in_vld;
  req_t   in_q;
  state_t st;
  state_t st_next;
  rsp_t   rsp_next;
  logic   adv;

  assign adv       = in_vld && (!rsp_valid || rsp_ready);
  assign req_ready = !in_vld || adv;

  i2cm_step u_step (
    .st       (st),
    .req      (in_q),
    .st_next  (st_next),
    .rsp_next (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req_ready) begin
      in_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      in_q <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= 5'd0;
      st.cmd        <= CMD_START;
      st.shift_byte <= 8'd0;
      st.scl_level  <= 1'b1;
      st.sda_level  <= 1'b1;
      st.sda_enable <= 1'b1;
      st.ack_seen   <= 1'b0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_data <= rsp_next;
    end
  end

  `I2CM_ASSERT_IMPL(a_done_busy, clk, rst, rsp_valid && rsp_data.done_res, rsp_data.busy_res)
  `I2CM_ASSERT_IMPL(a_rx_on_done, clk, rst, rsp_valid && rsp_data.rx_byte != 8'd0, rsp_data.done_res)
  `I2CM_ASSERT_IMPL(a_nack_on_done, clk, rst, rsp_valid && rsp_data.poll_nack, rsp_data.done_res)
  `I2CM_ASSERT_IMPL(a_idle_drives, clk, rst, rsp_valid && !rsp_data.busy_res, rsp_data.sda_drive)
  `I2CM_ASSERT_NEXT(a_done_idle, clk, rst, adv && rsp_next.done_res, st.phase == 5'd0)

endmodule
